### src/indexed_max_heap_queue_macros.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_MAX_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define IMHQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every clock, disabled in reset.
`define IMHQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### src/imhq_pkg.sv
// Package with operation and status codes and the fixed field widths.
`default_nettype none
package imhq_pkg;
    localparam int OP_BITS  = 3;
    localparam int ID_BITS  = 10;
    localparam int ID_COUNT = 1024;
    localparam int ST_BITS  = 2;
    localparam int KEY_BITS = 32;
    localparam int OUT_KEY_BITS = 32;
    localparam int OCC_BITS = 11;

    localparam logic [OP_BITS-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_BUILD   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_EXTRACT = 3'd3;
    localparam logic [OP_BITS-1:0] OP_UPDATE  = 3'd4;

    localparam logic [ST_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [ST_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_BITS-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_BITS-1:0] ST_ABSENT = 2'd3;
endpackage
`default_nettype wire

### src/imhq_heap_ram.sv
// Heap store: one write port, one read port, registered read data.
`default_nettype none
module imhq_heap_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 42
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);
    logic [DATA_BITS-1:0] mem [0:(1<<ADDR_BITS)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/imhq_pos_ram.sv
// Position map: slot of each id, cleared by a pass in the top level after reset.
`default_nettype none
module imhq_pos_ram #(
    parameter int POS_BITS = 11
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [imhq_pkg::ID_BITS-1:0] waddr,
    input  wire logic [POS_BITS-1:0]        wdata,
    input  wire logic [imhq_pkg::ID_BITS-1:0] raddr,
    output logic      [POS_BITS-1:0]        rdata
);
    import imhq_pkg::*;
    logic [POS_BITS-1:0] mem [0:ID_COUNT-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/indexed_max_heap_queue.sv
// Top level: indexed binary max-heap with sequencer over two memories.
//
//  channel | dir | ports                      | content
//  s_      | in  | s_tvalid s_tready s_tdata  | operation, item_id, key
//  m_      | out | m_tvalid m_tready m_tdata  | status, out_id, out_key, occupancy
//
// One item at a time. Insert and upward updates walk up one heap level per step
// (read parent, compare, write two entries); extract and downward updates walk
// down one level per step (read both children, compare, write two entries);
// build runs one sift down per inner node.
// After reset a clearing pass zeroes all 1024 entries of the position map; no item
// is accepted during it. The result waits in an output register; a stalled
// m_tready holds the result and the next item is only taken once it has left.
`default_nettype none
module indexed_max_heap_queue #(
    parameter int CAPACITY = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] operation, [12:3] item_id, [44:13] key, zero fill to 48
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] status, [11:2] out_id, [43:12] out_key, [54:44] occupancy, zero fill
    output logic [55:0]      m_tdata
);
    import imhq_pkg::*;

    localparam int PB = $clog2(CAPACITY + 1);     // slot/count width
    localparam int AB = $clog2(CAPACITY + 1);     // heap address width
    localparam int DB = ID_BITS + KEY_BITS;

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_POSRD = 5'd2,
                           S_DISP  = 5'd3,  S_RDPOS = 5'd4, S_GOTPOS = 5'd5,
                           S_UPRD  = 5'd6,  S_UPCMP = 5'd7, S_DNRD_L = 5'd8,
                           S_DNRD_R = 5'd9, S_DNCMP = 5'd10, S_WMAP1 = 5'd11,
                           S_DONE  = 5'd12, S_EXRD = 5'd13, S_EXLAST = 5'd14,
                           S_EXMAP = 5'd15, S_BNEXT = 5'd16, S_DNRD_C = 5'd17,
                           S_UPRD_P = 5'd18, S_WMAP2 = 5'd19, S_EXMAP2 = 5'd20;

    logic [4:0]            state_reg, state_next;
    logic [OP_BITS-1:0]    op_reg, op_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [PB-1:0]         cnt_reg, cnt_next;
    logic [PB-1:0]         pos_reg, pos_next;       // walking slot
    logic [DB-1:0]         cur_reg, cur_next;       // entry being sifted
    logic [DB-1:0]         oth_reg, oth_next;       // parent or chosen child
    logic [PB-1:0]         oslot_reg, oslot_next;
    logic [DB-1:0]         lch_reg, lch_next;
    logic [PB-1:0]         bidx_reg, bidx_next;     // build cursor
    logic                  build_reg, build_next;
    logic [ID_BITS-1:0]    clr_reg, clr_next;
    logic [ST_BITS-1:0]    st_reg, st_next;
    logic [ID_BITS-1:0]    oid_reg, oid_next;
    logic [KEY_BITS-1:0]   okey_reg, okey_next;
    logic                  mv_reg, mv_next;

    logic              h_we;
    logic [AB-1:0]     h_wa, h_ra;
    logic [DB-1:0]     h_wd, h_rd;
    logic              p_we;
    logic [ID_BITS-1:0] p_wa, p_ra;
    logic [PB-1:0]     p_wd, p_rd;

    imhq_heap_ram #(.ADDR_BITS(AB), .DATA_BITS(DB)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    imhq_pos_ram #(.POS_BITS(PB)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    function automatic logic signed [KEY_BITS-1:0] kof(input logic [DB-1:0] e);
        kof = e[DB-1:ID_BITS];
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, OCC_BITS'(cnt_reg), okey_reg[OUT_KEY_BITS-1:0], oid_reg, st_reg};

    logic [PB:0] lc;   // left child of pos_reg
    assign lc = {pos_reg, 1'b0};

    always_comb begin
        state_next = state_reg; op_next = op_reg; id_next = id_reg; key_next = key_reg;
        cnt_next = cnt_reg; pos_next = pos_reg; cur_next = cur_reg; oth_next = oth_reg;
        oslot_next = oslot_reg; lch_next = lch_reg; bidx_next = bidx_reg;
        build_next = build_reg; clr_next = clr_reg; st_next = st_reg;
        oid_next = oid_reg; okey_next = okey_reg; mv_next = mv_reg;
        h_we = 1'b0; h_wa = '0; h_wd = cur_reg; h_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = s_tdata[12:3];
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1; p_wa = clr_reg; p_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ID_BITS'(ID_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_next  = s_tdata[2:0];
                    id_next  = s_tdata[12:3];
                    key_next = s_tdata[13 +: KEY_BITS];
                    st_next = ST_OK; oid_next = '0; okey_next = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                // p_rd holds position of id; clamp stale slots
                pos_next = (p_rd > cnt_reg) ? '0 : p_rd;
                state_next = S_DONE;
                case (op_reg)
                    OP_INSERT, OP_APPEND, OP_UPDATE: begin
                        if ((p_rd > cnt_reg) || p_rd == '0) begin
                            if (op_reg == OP_UPDATE) begin
                                st_next = ST_ABSENT;
                            end else if (32'(cnt_reg) >= CAPACITY) begin
                                st_next = ST_FULL;
                            end else begin
                                cnt_next = cnt_reg + 1'b1;
                                pos_next = cnt_reg + 1'b1;
                                cur_next = {key_reg, id_reg};
                                h_we = 1'b1; h_wa = AB'(cnt_reg + 1'b1);
                                h_wd = {key_reg, id_reg};
                                p_we = 1'b1; p_wa = id_reg; p_wd = cnt_reg + 1'b1;
                                state_next = (op_reg == OP_INSERT) ? S_UPRD_P : S_DONE;
                            end
                        end else begin
                            h_ra = AB'(p_rd);
                            state_next = S_RDPOS;
                        end
                    end
                    OP_BUILD: begin
                        build_next = 1'b1;
                        bidx_next = cnt_reg >> 1;
                        state_next = S_BNEXT;
                    end
                    OP_EXTRACT: begin
                        if (cnt_reg == '0) begin
                            st_next = ST_EMPTY;
                        end else begin
                            h_ra = AB'(1);
                            state_next = S_EXRD;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RDPOS: begin
                // old entry of present id now in h_rd
                cur_next = {key_reg, id_reg};
                h_we = 1'b1; h_wa = AB'(pos_reg); h_wd = {key_reg, id_reg};
                if (op_reg == OP_APPEND) begin
                    state_next = S_DONE;
                end else if (kof(h_rd) < key_reg) begin
                    state_next = S_UPRD_P;
                end else begin
                    state_next = S_DNRD_L;
                end
            end
            S_UPRD_P: begin
                if (pos_reg <= PB'(1)) begin
                    state_next = S_DONE;
                end else begin
                    h_ra = AB'(pos_reg >> 1);
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (kof(h_rd) < kof(cur_reg)) begin
                    // parent moves down to pos, cur up to parent
                    h_we = 1'b1; h_wa = AB'(pos_reg); h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd[ID_BITS-1:0]; p_wd = pos_reg;
                    oth_next = h_rd;
                    pos_next = pos_reg >> 1;
                    state_next = S_WMAP1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_WMAP1: begin
                h_we = 1'b1; h_wa = AB'(pos_reg); h_wd = cur_reg;
                p_we = 1'b1; p_wa = cur_reg[ID_BITS-1:0]; p_wd = pos_reg;
                state_next = S_UPRD_P;
            end
            S_DNRD_L: begin
                if (pos_reg == '0 || lc > {1'b0, cnt_reg}) begin
                    state_next = build_reg ? S_BNEXT : S_DONE;
                end else begin
                    h_ra = AB'(lc);
                    state_next = S_DNRD_R;
                end
            end
            S_DNRD_R: begin
                lch_next = h_rd;
                h_ra = AB'(lc + 1'b1);
                state_next = S_DNRD_C;
            end
            S_DNRD_C: begin
                if ((lc + 1'b1) <= {1'b0, cnt_reg} && !(kof(lch_reg) > kof(h_rd))) begin
                    oth_next = h_rd; oslot_next = PB'(lc + 1'b1);
                end else begin
                    oth_next = lch_reg; oslot_next = PB'(lc);
                end
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                if (kof(oth_reg) > kof(cur_reg)) begin
                    h_we = 1'b1; h_wa = AB'(pos_reg); h_wd = oth_reg;
                    p_we = 1'b1; p_wa = oth_reg[ID_BITS-1:0]; p_wd = pos_reg;
                    pos_next = oslot_reg;
                    state_next = S_WMAP2;
                end else begin
                    state_next = build_reg ? S_BNEXT : S_DONE;
                end
            end
            S_WMAP2: begin
                h_we = 1'b1; h_wa = AB'(pos_reg); h_wd = cur_reg;
                p_we = 1'b1; p_wa = cur_reg[ID_BITS-1:0]; p_wd = pos_reg;
                state_next = S_DNRD_L;
            end
            S_BNEXT: begin
                if (bidx_reg == '0) begin
                    build_next = 1'b0;
                    state_next = S_DONE;
                end else begin
                    h_ra = AB'(bidx_reg);
                    pos_next = bidx_reg;
                    bidx_next = bidx_reg - 1'b1;
                    state_next = S_POSRD;
                end
            end
            S_POSRD: begin
                cur_next = h_rd;
                state_next = S_DNRD_L;
            end
            S_EXRD: begin
                oid_next = h_rd[ID_BITS-1:0];
                okey_next = KEY_BITS'(kof(h_rd));
                p_we = 1'b1; p_wa = h_rd[ID_BITS-1:0]; p_wd = '0;
                h_ra = AB'(cnt_reg);
                state_next = S_EXLAST;
            end
            S_EXLAST: begin
                cnt_next = cnt_reg - 1'b1;
                pos_next = PB'(1);
                cur_next = h_rd;
                if (cnt_reg > PB'(1)) begin
                    h_we = 1'b1; h_wa = AB'(1); h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd[ID_BITS-1:0]; p_wd = PB'(1);
                    state_next = S_DNRD_L;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; clr_reg <= '0; cnt_reg <= '0;
            mv_reg <= 1'b0; build_reg <= 1'b0;
        end else begin
            state_reg <= state_next; clr_reg <= clr_next; cnt_reg <= cnt_next;
            mv_reg <= mv_next; build_reg <= build_next;
        end
        op_reg <= op_next; id_reg <= id_next; key_reg <= key_next;
        pos_reg <= pos_next; cur_reg <= cur_next; oth_reg <= oth_next;
        oslot_reg <= oslot_next; lch_reg <= lch_next; bidx_reg <= bidx_next;
        st_reg <= st_next; oid_reg <= oid_next; okey_reg <= okey_next;
    end
endmodule
`default_nettype wire

### src/imhq_checker.sv
// Port checker for the heap queue, bound to the top level.
`default_nettype none
`include "indexed_max_heap_queue_macros.svh"
module imhq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    `IMHQ_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    `IMHQ_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input item changed while waiting")
    `IMHQ_ASSERT_IMPL(a_one, aclk, aresetn, s_tready, !m_tvalid, "input taken while result pending")
    `IMHQ_ASSERT_IMPL(a_empty, aclk, aresetn, m_tvalid && m_tdata[1:0] == 2'd2, m_tdata[54:44] == 11'd0, "empty with entries")
    `IMHQ_ASSERT_IMPL(a_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] != 2'd0, m_tdata[43:2] == 42'd0, "id or key on failure")
endmodule

bind indexed_max_heap_queue imhq_checker u_chk (.*);
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the indexed max-heap queue.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import imhq_pkg::*;

    localparam int HEAP_CAP   = 1024;
    localparam int IDLE_LIMIT = 200000;
    localparam int RANDOM_OPS = 300;
    localparam int MAX_REPORTS = 10;

    // One stimulus row: the item, plus an optional typed-in result.
    typedef struct {
        logic [2:0]        op;
        logic [9:0]        id;
        logic signed [31:0] key;
        bit                fixed;
        logic [1:0]        st;
        logic [9:0]        oid;
        logic [31:0]       okey;
        logic [10:0]       occ;
    } row_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [9:0]  oid;
        logic [31:0] okey;
        logic [10:0] occ;
    } heap_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    // Predictor state: slot 1 is the root; pos_of holds 0 for an absent id.
    logic [9:0]         slot_id  [1:HEAP_CAP];
    logic signed [31:0] slot_key [1:HEAP_CAP];
    int                 pos_of   [0:ID_COUNT-1];
    int                 held;

    heap_result_t pending_results[$];
    int  mismatches;
    int  idle_cycles;
    bit  stim_done;

    indexed_max_heap_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic void swap_slots(int a, int b);
        logic [9:0]         ti;
        logic signed [31:0] tk;
        ti = slot_id[a];  tk = slot_key[a];
        slot_id[a] = slot_id[b];  slot_key[a] = slot_key[b];
        slot_id[b] = ti;          slot_key[b] = tk;
        pos_of[slot_id[a]] = a;
        pos_of[slot_id[b]] = b;
    endfunction

    function automatic void bubble_up(int p);
        while (p > 1 && slot_key[p/2] < slot_key[p]) begin
            swap_slots(p/2, p);
            p = p / 2;
        end
    endfunction

    function automatic void push_down(int p);
        int l;
        int c;
        forever begin
            l = 2 * p;
            if (p == 0 || l > held) break;
            c = l;
            // Right child wins a tie.
            if (l + 1 <= held && !(slot_key[l] > slot_key[l+1])) c = l + 1;
            if (slot_key[c] > slot_key[p]) begin
                swap_slots(c, p);
                p = c;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void rekey(int p, logic signed [31:0] k);
        logic signed [31:0] old;
        old = slot_key[p];
        slot_key[p] = k;
        if (old < k) bubble_up(p);
        else push_down(p);
    endfunction

    function automatic heap_result_t apply_heap_op(logic [2:0] op, logic [9:0] id,
                                                   logic signed [31:0] k);
        heap_result_t r;
        int p;
        r = '{st: ST_OK, oid: '0, okey: '0, occ: '0};
        p = pos_of[id];
        if (p > held) p = 0;
        case (op)
            OP_INSERT, OP_APPEND: begin
                if (p != 0) begin
                    if (op == OP_INSERT) rekey(p, k);
                    else slot_key[p] = k;
                end else if (held >= HEAP_CAP) begin
                    r.st = ST_FULL;
                end else begin
                    held++;
                    slot_id[held] = id;
                    slot_key[held] = k;
                    pos_of[id] = held;
                    if (op == OP_INSERT) bubble_up(held);
                end
            end
            OP_BUILD: begin
                for (int j = held / 2; j >= 1; j--) push_down(j);
            end
            OP_EXTRACT: begin
                if (held == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    r.oid  = slot_id[1];
                    r.okey = slot_key[1];
                    pos_of[slot_id[1]] = 0;
                    if (held > 1) begin
                        slot_id[1] = slot_id[held];
                        slot_key[1] = slot_key[held];
                        pos_of[slot_id[1]] = 1;
                    end
                    held--;
                    push_down(1);
                end
            end
            OP_UPDATE: begin
                if (p == 0) r.st = ST_ABSENT;
                else rekey(p, k);
            end
            default: ;
        endcase
        r.occ = held[10:0];
        return r;
    endfunction

    // ---------------- stimulus ----------------
    // Hold tvalid across back-to-back items; drop it only for a gap.
    task automatic send_item(logic [2:0] op, logic [9:0] id, logic signed [31:0] k);
        int gap;
        // Random gap before the item: mostly short, sometimes long.
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, k, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic run_row(row_t row);
        heap_result_t r;
        r = apply_heap_op(row.op, row.id, row.key);
        if (row.fixed) begin
            // Trust the typed-in value over the predictor for this row.
            r = '{st: row.st, oid: row.oid, okey: row.okey, occ: row.occ};
        end
        pending_results.push_back(r);
        send_item(row.op, row.id, row.key);
    endtask

    function automatic row_t mk(logic [2:0] op, logic [9:0] id, logic signed [31:0] k);
        return '{op: op, id: id, key: k, fixed: 1'b0, st: '0, oid: '0, okey: '0, occ: '0};
    endfunction

    function automatic row_t mkx(logic [2:0] op, logic [9:0] id, logic signed [31:0] k,
                                 logic [1:0] st, logic [9:0] oid, logic [31:0] okey,
                                 logic [10:0] occ);
        return '{op: op, id: id, key: k, fixed: 1'b1, st: st, oid: oid, okey: okey,
                 occ: occ};
    endfunction

    // Pick a random key, biased toward the extremes and a narrow range so that ties occur.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'sh7FFFFFFF - $urandom_range(0, 2);
            2: return 32'sh80000000 + $urandom_range(0, 2);
            default: return $signed($urandom_range(0, 15)) - 8;
        endcase
    endfunction

    row_t directed[$];

    initial begin
        logic [2:0] op;
        logic [9:0] id;
        int         sel;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        stim_done = 1'b0;
        held = 0;
        for (int i = 0; i < ID_COUNT; i++) pos_of[i] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows: empty cases, extremes, ties, every operation.
        directed = '{
            mkx(OP_EXTRACT, 10'd0,   32'sd0,          ST_EMPTY,  '0, '0, 11'd0),
            mkx(OP_UPDATE,  10'd5,   32'sd9,          ST_ABSENT, '0, '0, 11'd0),
            mkx(OP_BUILD,   10'd0,   32'sd0,          ST_OK,     '0, '0, 11'd0),
            mkx(3'd5,       10'd0,   32'sd0,          ST_OK,     '0, '0, 11'd0),
            mkx(OP_INSERT,  10'd1023, 32'sh7FFFFFFF,  ST_OK,     '0, '0, 11'd1),
            mkx(OP_INSERT,  10'd0,   32'sh80000000,   ST_OK,     '0, '0, 11'd2),
            mkx(OP_EXTRACT, 10'd0,   32'sd0,          ST_OK,     10'd1023, 32'h7FFFFFFF,
                11'd1),
            mkx(OP_EXTRACT, 10'd0,   32'sd0,          ST_OK,     10'd0, 32'h80000000,
                11'd0),
            mk(OP_INSERT,  10'd10,  32'sd5),
            mk(OP_INSERT,  10'd11,  32'sd5),
            mk(OP_INSERT,  10'd12,  32'sd5),
            mk(OP_INSERT,  10'd10,  32'sd7),        // insert of a present id
            mk(OP_APPEND,  10'd11,  32'sd100),      // append of a present id
            mk(OP_APPEND,  10'd13,  32'sd50),
            mk(OP_APPEND,  10'd682, -32'sd3),
            mk(OP_UPDATE,  10'd12,  -32'sd20),
            mk(OP_BUILD,   10'd0,   32'sd0),
            mk(3'd6,       10'd341, 32'sh5555AAAA),
            mk(3'd7,       10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0),
            mk(OP_EXTRACT, 10'd0,   32'sd0)
        };
        foreach (directed[i]) run_row(directed[i]);

        // Fill to capacity once, try one more, then drain part of it.
        for (int i = 0; i < HEAP_CAP; i++)
            run_row(mk(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND, i[9:0],
                       pick_key()));
        run_row(mk(OP_INSERT, 10'd0, 32'sd1));           // present id at capacity
        // Hold off until the block has drained every result.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        run_row(mk(OP_BUILD, 10'd0, 32'sd0));
        for (int i = 0; i < 200; i++) run_row(mk(OP_EXTRACT, 10'd0, 32'sd0));
        // Refill with appends; ids still held are rewritten in place.
        for (int i = 0; i < 100; i++) run_row(mk(OP_APPEND, i[9:0], pick_key()));
        run_row(mk(OP_BUILD, 10'd0, 32'sd0));
        // Take the root out and put its id straight back.
        run_row(mk(OP_EXTRACT, 10'd0, 32'sd0));
        run_row(mk(OP_INSERT, pending_results[$].oid, 32'sd0));
        run_row(mk(OP_APPEND, 10'd1000 + 10'($urandom_range(0, 23)), 32'sd0));

        // Random part: small id pool mostly, with every operation mixed.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            sel = $urandom_range(0, 99);
            id  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
            if (sel < 30)      op = OP_INSERT;
            else if (sel < 40) op = OP_APPEND;
            else if (sel < 43) op = OP_BUILD;
            else if (sel < 75) op = OP_EXTRACT;
            else if (sel < 97) op = OP_UPDATE;
            else               op = 3'($urandom_range(5, 7));
            run_row(mk(op, id, pick_key()));
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------- result side ----------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            // Stretches of free flow alternate with random stalls.
            if ($urandom_range(0, 199) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end else if ($urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        heap_result_t want;
        heap_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{st: m_tdata[1:0], oid: m_tdata[11:2], okey: m_tdata[43:12],
                    occ: m_tdata[54:44]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: st=%0d id=%0d key=%h occ=%0d",
                             got.st, got.oid, got.okey, got.occ);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result differs: exp st=%0d id=%0d key=%h occ=%0d,",
                                  " got st=%0d id=%0d key=%h occ=%0d"},
                                 want.st, want.oid, want.okey, want.occ,
                                 got.st, got.oid, got.okey, got.occ);
                end
            end
        end
    end

    // ---------------- watchdog and end of run ----------------
    initial begin
        mismatches = 0;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            if (stim_done && pending_results.size() == 0) begin
                // Let any stray output surface before judging.
                repeat (200) @(posedge aclk);
                if (mismatches == 0 && pending_results.size() == 0)
                    $display("No mismatches found");
                else
                    $display("Mismatches found");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

### files.f
+incdir+src
src/imhq_pkg.sv
src/imhq_heap_ram.sv
src/imhq_pos_ram.sv
src/indexed_max_heap_queue.sv
src/imhq_checker.sv
tb/testbench.sv
